// File: rtl/core/dbpc_pkg.sv
// shared constants, types and helpers for the debounced button press classifier
// no dependencies; used by dbpc_core and debounced_button_press_classifier_top
package dbpc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
    localparam int ADDR_BITS  = 2;
    localparam int TDATA_BITS = 8;

    localparam logic [ADDR_BITS-1:0] REG_DEBOUNCE   = ADDR_BITS'(0);
    localparam logic [ADDR_BITS-1:0] REG_LONG_PRESS = ADDR_BITS'(1);

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = CFG_BITS'(50);
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(1000);

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CFG_BITS-1:0]   cfg_word_t;

    typedef struct packed {
        logic long_press;
        logic short_press;
        logic pressed;
    } result_t;

    // counter increment that sticks at full scale
    function automatic count_t sat_inc(input count_t v);
        count_t r;
        if (v == '1) begin
            r = v;
        end else begin
            r = v + count_t'(1);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/dbpc_core.sv
// debounce and press classification state, one sample per step
// depends on dbpc_pkg
module dbpc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                sample,
    input  dbpc_pkg::cfg_word_t debounce_ticks,
    input  dbpc_pkg::cfg_word_t long_press_ticks,
    output dbpc_pkg::result_t   result
);

    logic               prev_reg,   prev_next;
    dbpc_pkg::count_t   stable_reg, stable_next;
    logic               level_reg,  level_next;
    dbpc_pkg::count_t   hold_reg,   hold_next;
    logic               rep_reg,    rep_next;
    logic               ever_reg,   ever_next;

    logic adopt;
    logic new_press;
    logic rep_tmp;
    logic hold_below;

    always_comb begin
        stable_next = (sample != prev_reg) ? '0 : dbpc_pkg::sat_inc(stable_reg);
        prev_next   = sample;
        adopt       = (dbpc_pkg::CMP_BITS'(stable_next) > dbpc_pkg::CMP_BITS'(debounce_ticks))
                      && (sample != level_reg);
        new_press   = adopt && sample;
        level_next  = adopt ? sample : level_reg;
        hold_next   = new_press ? '0 : dbpc_pkg::sat_inc(hold_reg);
        rep_tmp     = new_press ? 1'b0 : rep_reg;
        ever_next   = ever_reg | new_press;
        hold_below  = dbpc_pkg::CMP_BITS'(hold_next) < dbpc_pkg::CMP_BITS'(long_press_ticks);

        result.pressed     = level_next;
        result.short_press = !level_next && !rep_tmp && ever_next && hold_below;
        result.long_press  = level_next && !rep_tmp && !hold_below;
        rep_next           = rep_tmp | result.short_press | result.long_press;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= 1'b0;
            stable_reg <= '0;
            level_reg  <= 1'b0;
            hold_reg   <= '0;
            rep_reg    <= 1'b0;
            ever_reg   <= 1'b0;
        end else if (step) begin
            prev_reg   <= prev_next;
            stable_reg <= stable_next;
            level_reg  <= level_next;
            hold_reg   <= hold_next;
            rep_reg    <= rep_next;
            ever_reg   <= ever_next;
        end
    end

endmodule

// File: rtl/core/debounced_button_press_classifier_top.sv
// top level: stream handshake, configuration registers and result register
// depends on dbpc_pkg and dbpc_core
//
// usage: one s_ transaction per tick of the sampled button pin; s_tdata[0]
// carries the raw level, 0 meaning pressed. every input transaction gives
// exactly one m_ transaction: m_tdata[0] debounced pressed state,
// m_tdata[1] one-tick short press pulse, m_tdata[2] one-tick long press pulse.
// a sample is caught in an input register, then classified combinationally
// into the result register once that register is free; m_tdata shows the
// result register.
// one transaction per cycle is sustained while m_tready stays high; the
// classifier state update is combinational compares and counter increments.
// when the receiver stalls, the result register holds and the input register
// keeps accepting until both are full, then s_tready drops.
// reset (aresetn low, synchronous) empties both registers, clears the state
// and loads debounce_ticks = 50, long_press_ticks = 1000.
// cfg_we writes cfg_wdata to register cfg_addr (0 debounce, 1 long press);
// other indexes are ignored; write only while the block is idle.
module debounced_button_press_classifier_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dbpc_pkg::TDATA_BITS-1:0] s_tdata,   // [0] button_level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dbpc_pkg::TDATA_BITS-1:0] m_tdata,   // [0] pressed [1] short_press [2] long_press
    input  logic                            cfg_we,
    input  logic [dbpc_pkg::ADDR_BITS-1:0]  cfg_addr,
    input  logic [dbpc_pkg::CFG_BITS-1:0]   cfg_wdata
);

    dbpc_pkg::cfg_word_t debounce_reg;
    dbpc_pkg::cfg_word_t long_press_reg;

    logic              in_valid_reg;
    logic              in_level_reg;
    logic              out_valid_reg;
    dbpc_pkg::result_t out_reg;
    dbpc_pkg::result_t result;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= dbpc_pkg::DEBOUNCE_RESET;
            long_press_reg <= dbpc_pkg::LONG_PRESS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                dbpc_pkg::REG_DEBOUNCE: begin
                    debounce_reg <= cfg_wdata;
                end
                dbpc_pkg::REG_LONG_PRESS: begin
                    long_press_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    dbpc_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (advance),
        .sample           (!in_level_reg),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_press_reg),
        .result           (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dbpc_pkg::TDATA_BITS - 3){1'b0}},
                       out_reg.long_press, out_reg.short_press, out_reg.pressed};

    // a press is reported as short or long, never both at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.short_press && out_reg.long_press))
        else $error("short and long press pulses together");

    // short press only after release, long press only while held
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.short_press |-> !out_reg.pressed)
        else $error("short press pulse while pressed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.long_press |-> out_reg.pressed)
        else $error("long press pulse while released");

    // a stalled result must not be overwritten by the core
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_reg))
        else $error("pending result lost");

endmodule
